/* rtl/estp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package estp_pkg;

  // Fixed point: levels are in units of 2^-FRACTION_BITS.
  localparam int FRACTION_BITS = 10;
  localparam int LVL_W         = FRACTION_BITS + 1;
  localparam int ONE_W         = 17;
  localparam logic [ONE_W-1:0] LEVEL_ONE = ONE_W'(1 << FRACTION_BITS);

  // Field widths.
  localparam int NOW_W      = 32;
  localparam int POT_W      = 10;
  localparam int PULSE_W    = 12;
  localparam int LEVEL_W    = 11;
  localparam int RUN_W      = 17;
  localparam int STEPS_W    = 5;
  localparam int MAXL_W     = 11;
  localparam int CFG_DATA_W = 17;
  localparam int REG_IDX_W  = 3;

  // The potentiometer full scale is 1024 counts.
  localparam int POT_FULL_BITS = 10;
  localparam int POT_SCALE_W   = POT_W + FRACTION_BITS;

  // The last step is held for this long before the run ends.
  localparam logic [RUN_W-1:0] FINAL_STEP_MS = RUN_W'(3000);

  // Shared divider.
  localparam int DIV_N_W   = 32;
  localparam int DIV_D_W   = 17;
  localparam int DIV_CNT_W = 6;

  // Product widths.
  localparam int KTOP_W  = STEPS_W + LVL_W;
  localparam int PPROD_W = LVL_W + PULSE_W;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MODE_AUTO    = 3'd0,
    REG_RUN_TIME_MS  = 3'd1,
    REG_STEP_COUNT   = 3'd2,
    REG_MAX_LEVEL    = 3'd3,
    REG_MIN_PULSE_US = 3'd4,
    REG_MAX_PULSE_US = 3'd5
  } estp_reg_t;

  typedef struct packed {
    logic                 mode_auto;
    logic [RUN_W-1:0]     run_time_ms;
    logic [STEPS_W-1:0]   step_count;
    logic [MAXL_W-1:0]    max_level;
    logic [PULSE_W-1:0]   min_pulse_us;
    logic [PULSE_W-1:0]   max_pulse_us;
  } estp_cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_N_W-1:0]   dividend;
    logic [DIV_D_W-1:0]   divisor;
    logic [DIV_CNT_W-1:0] iters;
  } estp_div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_N_W-1:0]   quotient;
  } estp_div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN,
    ST_K,
    ST_LVL,
    ST_MUL,
    ST_OUT
  } estp_state_t;

endpackage
`default_nettype wire

/* rtl/estp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface estp_in_if;
  import estp_pkg::*;

  logic                valid;
  logic                ready;
  logic [NOW_W-1:0]    now_ms;
  logic [POT_W-1:0]    pot_sample;
  logic                arm;

  modport source (output valid, now_ms, pot_sample, arm, input ready);
  modport sink   (input valid, now_ms, pot_sample, arm, output ready);
endinterface

interface estp_out_if;
  import estp_pkg::*;

  logic                valid;
  logic                ready;
  logic [PULSE_W-1:0]  pulse_us;
  logic [LEVEL_W-1:0]  level;
  logic                test_done;

  modport source (output valid, pulse_us, level, test_done, input ready);
  modport sink   (input valid, pulse_us, level, test_done, output ready);
endinterface
`default_nettype wire

/* rtl/estp_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
module estp_cfg (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_we,
  input  wire [estp_pkg::REG_IDX_W-1:0]  cfg_idx,
  input  wire [estp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output estp_pkg::estp_cfg_t            cfg
);
  import estp_pkg::*;

  estp_cfg_t cfg_r;
  estp_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (estp_reg_t'(cfg_idx))
        REG_MODE_AUTO:    cfg_nxt.mode_auto    = cfg_wdata[0];
        REG_RUN_TIME_MS:  cfg_nxt.run_time_ms  = cfg_wdata[RUN_W-1:0];
        REG_STEP_COUNT:   cfg_nxt.step_count   = cfg_wdata[STEPS_W-1:0];
        REG_MAX_LEVEL:    cfg_nxt.max_level    = cfg_wdata[MAXL_W-1:0];
        REG_MIN_PULSE_US: cfg_nxt.min_pulse_us = cfg_wdata[PULSE_W-1:0];
        REG_MAX_PULSE_US: cfg_nxt.max_pulse_us = cfg_wdata[PULSE_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode_auto    <= 1'b1;
      cfg_r.run_time_ms  <= RUN_W'(5000);
      cfg_r.step_count   <= STEPS_W'(5);
      cfg_r.max_level    <= MAXL_W'(1024);
      cfg_r.min_pulse_us <= PULSE_W'(1030);
      cfg_r.max_pulse_us <= PULSE_W'(2000);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

/* rtl/estp_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle. The dividend arrives
// left-aligned so that only the requested number of bits is iterated.
module estp_div (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire estp_pkg::estp_div_req_t req,
  output estp_pkg::estp_div_rsp_t      rsp
);
  import estp_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_D_W-1:0]   rem_r, rem_nxt;
  logic [DIV_N_W-1:0]   quo_r, quo_nxt;
  logic [DIV_D_W-1:0]   dsr_r, dsr_nxt;
  logic [DIV_D_W:0]     trial;
  logic [DIV_D_W:0]     diff;
  logic                 ge;

  assign trial = {rem_r, quo_r[DIV_N_W-1]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.iters;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      quo_nxt = {quo_r[DIV_N_W-2:0], ge};
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire

/* rtl/esc_stepped_throttle_pulse.sv */
`timescale 1ns / 1ps
`default_nettype none
// Potentiometer mode passes from the input transfer through ST_MUL and ST_OUT into the
// output register; automatic mode first runs three divisions on the shared divider (step
// length, step index and level) and skips the last when the level saturates or the run ends.
// One update at a time goes through the shared divider; a new input is taken once
// the result sits in the output register. Reset (synchronous, active low) restores the
// register defaults, stops the test, clears the done flag and empties the output register.
module esc_stepped_throttle_pulse (
  input  wire                            clk,
  input  wire                            rst_n,
  estp_in_if.sink                        in_ch,
  estp_out_if.source                     out_ch,
  input  wire                            cfg_we,
  input  wire [estp_pkg::REG_IDX_W-1:0]  cfg_idx,
  input  wire [estp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import estp_pkg::*;

  estp_cfg_t     cfg;
  estp_div_req_t div_req;
  estp_div_rsp_t div_rsp;

  estp_state_t state_r, state_nxt;

  // Test state.
  logic [NOW_W-1:0]   start_r, start_nxt;
  logic               running_r, running_nxt;
  logic               done_flag_r, done_flag_nxt;

  // Working registers.
  logic [NOW_W-1:0]   elapsed_r, elapsed_nxt;
  logic [LVL_W-1:0]   lvl_r, lvl_nxt;
  logic [PPROD_W-1:0] prod_r, prod_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic [PULSE_W-1:0] pulse_r, pulse_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               tdone_r, tdone_nxt;

  // Derived values.
  logic               in_xfer;
  logic               out_load;
  logic [STEPS_W-1:0] steps;
  logic [RUN_W-1:0]   span;
  logic [LVL_W-1:0]   top_lvl;
  logic               running_eff;
  logic [NOW_W-1:0]   start_eff;
  logic [LVL_W-1:0]   pot_lvl;
  logic [DIV_D_W-1:0] step_len;
  logic               run_over;
  logic               k_sat;
  logic [STEPS_W-1:0] k_small;
  logic [KTOP_W-1:0]  ktop;
  logic [PULSE_W-1:0] pulse_span;
  logic [PULSE_W:0]   pulse_sum;
  logic [PULSE_W-1:0] pulse_val;

  estp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  estp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  // A zero step count is treated as a single step.
  assign steps = (cfg.step_count == '0) ? STEPS_W'(1) : cfg.step_count;

  // The time spent climbing excludes the final hold, and cannot go negative.
  assign span = (cfg.run_time_ms > FINAL_STEP_MS) ? cfg.run_time_ms - FINAL_STEP_MS : '0;

  assign top_lvl = (ONE_W'(cfg.max_level) > LEVEL_ONE) ? LVL_W'(LEVEL_ONE)
                                                        : LVL_W'(cfg.max_level);

  // Arm restarts the test; the first automatic update then latches its own stamp.
  assign running_eff = in_ch.arm ? 1'b0 : running_r;
  assign start_eff   = running_eff ? start_r : in_ch.now_ms;

  assign pot_lvl = LVL_W'((POT_SCALE_W'(in_ch.pot_sample) << FRACTION_BITS) >> POT_FULL_BITS);

  // A step length of zero would stall the staircase, so it is raised to one millisecond.
  assign step_len = (div_rsp.quotient[DIV_D_W-1:0] == '0) ? DIV_D_W'(1)
                                                          : div_rsp.quotient[DIV_D_W-1:0];

  assign run_over = elapsed_r >= NOW_W'(cfg.run_time_ms);

  // Once the step index reaches the step count the level is at least the top, so the
  // clamp decides it; below that the index is small and the product stays narrow.
  assign k_sat   = div_rsp.quotient >= (DIV_N_W'(steps) - DIV_N_W'(1));
  assign k_small = STEPS_W'(div_rsp.quotient) + STEPS_W'(1);
  assign ktop    = KTOP_W'(k_small) * KTOP_W'(top_lvl);

  assign pulse_span = cfg.max_pulse_us - cfg.min_pulse_us;
  assign pulse_sum  = (PULSE_W + 1)'(cfg.min_pulse_us)
                    + (PULSE_W + 1)'(prod_r >> FRACTION_BITS);

  // Inverted limits pin the pulse to the minimum; otherwise clamp at the maximum.
  always_comb begin
    if (cfg.max_pulse_us < cfg.min_pulse_us) begin
      pulse_val = cfg.min_pulse_us;
    end else if (pulse_sum > (PULSE_W + 1)'(cfg.max_pulse_us)) begin
      pulse_val = cfg.max_pulse_us;
    end else begin
      pulse_val = pulse_sum[PULSE_W-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = cfg.mode_auto ? ST_LEN : ST_MUL;
        end
      end
      ST_LEN: begin
        if (div_rsp.done) begin
          state_nxt = ST_K;
        end
      end
      ST_K: begin
        if (div_rsp.done) begin
          state_nxt = (run_over || k_sat) ? ST_MUL : ST_LVL;
        end
      end
      ST_LVL: begin
        if (div_rsp.done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs and datapath.
  always_comb begin
    div_req       = '0;
    start_nxt     = start_r;
    running_nxt   = running_r;
    done_flag_nxt = done_flag_r;
    elapsed_nxt   = elapsed_r;
    lvl_nxt       = lvl_r;
    prod_nxt      = prod_r;
    pulse_nxt     = pulse_r;
    level_nxt     = level_r;
    tdone_nxt     = tdone_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          running_nxt = running_eff;
          if (cfg.mode_auto) begin
            start_nxt        = start_eff;
            running_nxt      = 1'b1;
            elapsed_nxt      = in_ch.now_ms - start_eff;
            // Step length: span over the number of rises, or the whole span for one step.
            div_req.start    = 1'b1;
            div_req.dividend = DIV_N_W'(span) << (DIV_N_W - RUN_W);
            div_req.divisor  = (steps > STEPS_W'(1)) ? DIV_D_W'(steps - STEPS_W'(1))
                                                     : DIV_D_W'(1);
            div_req.iters    = DIV_CNT_W'(RUN_W);
          end else begin
            lvl_nxt = pot_lvl;
          end
        end
      end
      ST_LEN: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = elapsed_r;
          div_req.divisor  = step_len;
          div_req.iters    = DIV_CNT_W'(DIV_N_W);
        end
      end
      ST_K: begin
        if (div_rsp.done) begin
          if (run_over) begin
            lvl_nxt       = '0;
            done_flag_nxt = 1'b1;
          end else if (k_sat) begin
            lvl_nxt = top_lvl;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_N_W'(ktop) << (DIV_N_W - KTOP_W);
            div_req.divisor  = DIV_D_W'(steps);
            div_req.iters    = DIV_CNT_W'(KTOP_W);
          end
        end
      end
      ST_LVL: begin
        if (div_rsp.done) begin
          lvl_nxt = LVL_W'(div_rsp.quotient);
        end
      end
      ST_MUL: begin
        prod_nxt = PPROD_W'(lvl_r) * PPROD_W'(pulse_span);
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          pulse_nxt     = pulse_val;
          level_nxt     = LEVEL_W'(lvl_r);
          tdone_nxt     = done_flag_r;
        end
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= '0;
      running_r   <= 1'b0;
      done_flag_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      running_r   <= running_nxt;
      done_flag_r <= done_flag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    elapsed_r <= elapsed_nxt;
    lvl_r     <= lvl_nxt;
    prod_r    <= prod_nxt;
    pulse_r   <= pulse_nxt;
    level_r   <= level_nxt;
    tdone_r   <= tdone_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pulse_us  = pulse_r;
  assign out_ch.level     = level_r;
  assign out_ch.test_done = tdone_r;

endmodule
`default_nettype wire

/* rtl/estp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module estp_checker (
  input wire                         clk,
  input wire                         rst_n,
  input wire                         in_valid,
  input wire                         in_ready,
  input wire                         out_valid,
  input wire                         out_ready,
  input wire [estp_pkg::PULSE_W-1:0] out_pulse_us,
  input wire [estp_pkg::LEVEL_W-1:0] out_level,
  input wire                         out_test_done
);
  import estp_pkg::*;

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pend_r, pend_nxt;
  logic       seen_done_r, seen_done_nxt;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_comb begin
    pend_nxt      = pend_r + 2'(in_xfer) - 2'(out_xfer);
    seen_done_nxt = seen_done_r || (out_xfer && out_test_done);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      seen_done_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      seen_done_r <= seen_done_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pulse_us) && $stable(out_level)
                                && $stable(out_test_done))
    else $error("result changed while stalled");

  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("input taken while an update is in progress");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result shown with no update outstanding");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> pend_r < 2'd2)
    else $error("more than one update accepted ahead of its result");

  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && seen_done_r |-> out_test_done)
    else $error("test done flag cleared without reset");

endmodule

bind esc_stepped_throttle_pulse estp_checker u_estp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_pulse_us  (out_ch.pulse_us),
  .out_level     (out_ch.level),
  .out_test_done (out_ch.test_done)
);
`default_nettype wire

/* verif/estp_pulse_monitor.sv */
`timescale 1ns / 1ps
module estp_pulse_monitor
  import estp_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  estp_in_if                   in_ch,
  estp_out_if                  out_ch,
  input  wire                  cfg_we,
  input  wire [REG_IDX_W-1:0]  cfg_idx,
  input  wire [CFG_DATA_W-1:0] cfg_wdata,
  output int                   mismatches,
  output int                   pending
);

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_us;
    logic [LEVEL_W-1:0] level;
    logic               test_done;
  } pulse_result_t;

  localparam estp_cfg_t SETTINGS_AT_RESET = '{
    mode_auto: 1'b1, run_time_ms: 17'd5000, step_count: 5'd5,
    max_level: 11'd1024, min_pulse_us: 12'd1030, max_pulse_us: 12'd2000
  };

  estp_cfg_t        regs;
  logic [NOW_W-1:0] start_stamp;
  logic             test_running;
  logic             done_flag;
  pulse_result_t    expected_pulses[$];
  pulse_result_t    oldest;

  // Works out one update and advances the test state, as the block does.
  function automatic pulse_result_t next_pulse(input logic [NOW_W-1:0] now,
                                               input logic [POT_W-1:0] pot,
                                               input logic arm);
    logic [63:0]      steps, top, span, step_len, k, lvl, lo, hi, p;
    logic [NOW_W-1:0] elapsed;
    pulse_result_t    r;
    if (arm) test_running = 1'b0;
    if (regs.mode_auto) begin
      steps = (regs.step_count != '0) ? 64'(regs.step_count) : 64'd1;
      top = (64'(regs.max_level) > 64'(LEVEL_ONE)) ? 64'(LEVEL_ONE) : 64'(regs.max_level);
      span = (regs.run_time_ms > FINAL_STEP_MS) ? 64'(regs.run_time_ms - FINAL_STEP_MS)
                                                : 64'd0;
      step_len = (steps > 64'd1) ? span / (steps - 64'd1) : span;
      if (step_len == 64'd0) step_len = 64'd1;
      if (!test_running) begin
        start_stamp = now;
        test_running = 1'b1;
      end
      elapsed = now - start_stamp;
      k = 64'(elapsed) / step_len + 64'd1;
      lvl = k * top / steps;
      if (lvl > top) lvl = top;
      if (64'(elapsed) >= 64'(regs.run_time_ms)) begin
        lvl = 64'd0;
        done_flag = 1'b1;
      end
    end else begin
      lvl = (64'(pot) << FRACTION_BITS) >> POT_FULL_BITS;
    end
    lo = 64'(regs.min_pulse_us);
    hi = 64'(regs.max_pulse_us);
    if (hi < lo) begin
      p = lo;
    end else begin
      p = lo + ((lvl * (hi - lo)) >> FRACTION_BITS);
      if (p > hi) p = hi;
    end
    r.pulse_us  = p[PULSE_W-1:0];
    r.level     = lvl[LEVEL_W-1:0];
    r.test_done = done_flag;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      regs = SETTINGS_AT_RESET;
      start_stamp = '0;
      test_running = 1'b0;
      done_flag = 1'b0;
      expected_pulses.delete();
    end else begin
      if (cfg_we) begin
        case (estp_reg_t'(cfg_idx))
          REG_MODE_AUTO:    regs.mode_auto    = cfg_wdata[0];
          REG_RUN_TIME_MS:  regs.run_time_ms  = cfg_wdata[RUN_W-1:0];
          REG_STEP_COUNT:   regs.step_count   = cfg_wdata[STEPS_W-1:0];
          REG_MAX_LEVEL:    regs.max_level    = cfg_wdata[MAXL_W-1:0];
          REG_MIN_PULSE_US: regs.min_pulse_us = cfg_wdata[PULSE_W-1:0];
          REG_MAX_PULSE_US: regs.max_pulse_us = cfg_wdata[PULSE_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pulses.size() == 0) begin
          $error("unexpected result: pulse_us %0d level %0d test_done %0d",
                 out_ch.pulse_us, out_ch.level, out_ch.test_done);
          mismatches++;
        end else begin
          oldest = expected_pulses.pop_front();
          if (out_ch.pulse_us !== oldest.pulse_us) begin
            $error("pulse_us expected %0d actual %0d", oldest.pulse_us, out_ch.pulse_us);
            mismatches++;
          end
          if (out_ch.level !== oldest.level) begin
            $error("level expected %0d actual %0d", oldest.level, out_ch.level);
            mismatches++;
          end
          if (out_ch.test_done !== oldest.test_done) begin
            $error("test_done expected %0d actual %0d", oldest.test_done, out_ch.test_done);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_pulses.push_back(next_pulse(in_ch.now_ms, in_ch.pot_sample, in_ch.arm));
    end
    pending = expected_pulses.size();
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import estp_pkg::*;

  // A run with no transfer at all for this many cycles counts as hung. The worst honest
  // gap is the long receiver hold-off plus one automatic update, far below this.
  localparam int QUIET_LIMIT = 5000;
  // Length of the deliberate receiver hold-off that backs the block up.
  localparam int HOLD_CYCLES = 400;
  // Extra cycles after the last result, a bit over the slowest automatic update.
  localparam int TAIL_CYCLES = 100;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 198;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  estp_in_if  in_bus ();
  estp_out_if out_bus ();

  int mismatches;
  int pending;
  int quiet_cycles = 0;
  int send_idle = 0;
  int recv_stall = 0;
  bit hold_request = 1'b0;

  always #4 clk = ~clk;

  esc_stepped_throttle_pulse u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // The monitor watches both channels and the register port, predicts each result and
  // compares; this module only makes stimulus and gives the verdict.
  estp_pulse_monitor u_monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_bus),
    .out_ch     (out_bus),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // The watchdog restarts its count on any transfer, on either channel.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver. It stalls at random with the current stall percentage. When a hold-off is
  // requested it keeps ready low for a long stretch that it counts itself, while the
  // sender goes on offering updates, so the block fills and stops taking input.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  // Offers one update and returns at the edge where it transfers, or after the idle stretch
  // that follows it. Valid stays high afterward unless the sender decides to idle, so
  // back-to-back updates never lower and raise valid in the same step.
  task automatic offer(input logic [NOW_W-1:0] now, input logic [POT_W-1:0] pot,
                       input logic arm);
    in_bus.valid      <= 1'b1;
    in_bus.now_ms     <= now;
    in_bus.pot_sample <= pot;
    in_bus.arm        <= arm;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if ($urandom_range(99) < send_idle) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every predicted result has been taken, which also
  // means the block is idle, since every update gives exactly one result.
  task automatic drain;
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Leaves cfg_we high between consecutive writes; the caller lowers it once.
  task automatic put_reg(input estp_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic apply_settings(input estp_cfg_t s);
    put_reg(REG_MODE_AUTO,    CFG_DATA_W'(s.mode_auto));
    put_reg(REG_RUN_TIME_MS,  CFG_DATA_W'(s.run_time_ms));
    put_reg(REG_STEP_COUNT,   CFG_DATA_W'(s.step_count));
    put_reg(REG_MAX_LEVEL,    CFG_DATA_W'(s.max_level));
    put_reg(REG_MIN_PULSE_US, CFG_DATA_W'(s.min_pulse_us));
    put_reg(REG_MAX_PULSE_US, CFG_DATA_W'(s.max_pulse_us));
    cfg_we <= 1'b0;
  endtask

  // Mostly settings inside the documented ranges, with every so often one of the corner
  // cases: a run shorter than or close to the final step, a step count of zero or above twenty, a
  // maximum level above one, or pulse limits given the wrong way round.
  function automatic estp_cfg_t random_settings();
    estp_cfg_t          s;
    logic [PULSE_W-1:0] swap;
    s.mode_auto    = ($urandom_range(99) < 75);
    s.run_time_ms  = RUN_W'($urandom_range(120000, 5000));
    s.step_count   = STEPS_W'($urandom_range(20, 1));
    s.max_level    = MAXL_W'($urandom_range(1024, 10));
    s.max_pulse_us = PULSE_W'($urandom_range(4095, 0));
    s.min_pulse_us = PULSE_W'($urandom_range(s.max_pulse_us, 0));
    case ($urandom_range(7))
      0: s.run_time_ms = RUN_W'($urandom_range(3200, 0));
      1: s.step_count = ($urandom_range(1) != 0) ? STEPS_W'($urandom_range(31, 21)) : '0;
      2: s.max_level = MAXL_W'($urandom_range(2047, 1025));
      3: begin
        swap = s.min_pulse_us;
        s.min_pulse_us = s.max_pulse_us;
        s.max_pulse_us = swap;
      end
      default: ;
    endcase
    return s;
  endfunction

  // One random phase. Most updates form well-formed automatic tests: an arm with a fresh
  // start time, sometimes just below the timestamp wrap, then timestamps advancing by
  // about a twenty-fifth of the run time so the test climbs its steps, runs past its end
  // and shows the sticky done flag. The rest is noise with random stamps and arm bits.
  task automatic run_phase(input estp_cfg_t s, input int count);
    logic [NOW_W-1:0] now;
    logic             arm;
    int               seq_left;
    int               stride;
    now = '0;
    seq_left = 0;
    stride = 2 * int'(s.run_time_ms) / 25 + 1;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 8) begin
        now = $urandom;
        arm = $urandom_range(1);
        if ($urandom_range(1) != 0) seq_left = 0;
      end else if (seq_left == 0) begin
        if ($urandom_range(3) == 0) begin
          now = 32'hFFFF_FFFF - NOW_W'($urandom_range(int'(s.run_time_ms)));
        end else begin
          now = $urandom;
        end
        arm = 1'b1;
        seq_left = $urandom_range(40, 20);
      end else begin
        now = now + NOW_W'($urandom_range(stride, 1));
        arm = 1'b0;
        seq_left--;
      end
      offer(now, POT_W'($urandom_range(1023)), arm);
    end
  endtask

  initial begin
    estp_cfg_t s;
    in_bus.valid      = 1'b0;
    in_bus.now_ms     = '0;
    in_bus.pot_sample = '0;
    in_bus.arm        = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, no idling. First the settings at reset: a five second test with
    // five steps, checked at step boundaries, at the end, and then restarted by arm while
    // the done flag stays set, with the elapsed time crossing the timestamp wrap.
    offer(32'd0, 10'd0, 1'b1);
    offer(32'd999, 10'd1023, 1'b0);
    offer(32'd1000, 10'd0, 1'b0);
    offer(32'd2000, 10'd512, 1'b0);
    offer(32'd4999, 10'd0, 1'b0);
    offer(32'd5000, 10'd0, 1'b0);
    offer(32'hFFFF_FFFF, 10'd1023, 1'b1);
    offer(32'h0000_03E7, 10'd0, 1'b0);
    drain();

    // Potentiometer mode over the full pulse range; arm only touches the test state.
    apply_settings('{mode_auto: 1'b0, run_time_ms: 17'd5000, step_count: 5'd5,
                     max_level: 11'd1024, min_pulse_us: 12'd0, max_pulse_us: 12'd4095});
    offer(32'd0, 10'd0, 1'b0);
    offer(32'hFFFF_FFFF, 10'd1023, 1'b0);
    offer(32'h5555_5555, 10'd341, 1'b1);
    offer(32'hAAAA_AAAA, 10'd682, 1'b0);
    drain();

    // Zero run time, zero step count, a saturating maximum level and inverted limits.
    apply_settings('{mode_auto: 1'b1, run_time_ms: 17'd0, step_count: 5'd0,
                     max_level: 11'd2047, min_pulse_us: 12'd4095, max_pulse_us: 12'd0});
    offer(32'd100, 10'd0, 1'b1);
    offer(32'd100, 10'd0, 1'b0);
    offer(32'd101, 10'd0, 1'b1);
    drain();

    // A single step just over the final step length, smallest level, equal limits.
    apply_settings('{mode_auto: 1'b1, run_time_ms: 17'd3001, step_count: 5'd1,
                     max_level: 11'd10, min_pulse_us: 12'd1000, max_pulse_us: 12'd1000});
    offer(32'd7, 10'd0, 1'b1);
    offer(32'd8, 10'd0, 1'b0);
    offer(32'd3007, 10'd0, 1'b0);
    offer(32'd3008, 10'd0, 1'b0);
    drain();

    // Longest run the register holds with the largest step count it holds.
    apply_settings('{mode_auto: 1'b1, run_time_ms: 17'd131071, step_count: 5'd31,
                     max_level: 11'd1024, min_pulse_us: 12'd1030, max_pulse_us: 12'd2000});
    offer(32'd0, 10'd0, 1'b1);
    offer(32'd65535, 10'd0, 1'b0);
    offer(32'd131070, 10'd0, 1'b0);
    offer(32'd131071, 10'd0, 1'b0);
    drain();

    // Random phases. Idling rotates through none, sender, receiver and both; two of the
    // phases open with a long receiver hold-off. Each phase ends by draining, so the
    // sender also pauses until every expected result has come.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: s = '{mode_auto: 1'b1, run_time_ms: 17'd120000, step_count: 5'd20,
                 max_level: 11'd1024, min_pulse_us: 12'd0, max_pulse_us: 12'd4095};
        1: s = '{mode_auto: 1'b1, run_time_ms: 17'd5000, step_count: 5'd1,
                 max_level: 11'd10, min_pulse_us: 12'd4095, max_pulse_us: 12'd4095};
        default: s = random_settings();
      endcase
      apply_settings(s);
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 74; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 74; end
        default: begin send_idle = 19; recv_stall = 19; end
      endcase
      if (p == 2 || p == 6) hold_request = 1'b1;
      run_phase(s, PHASE_ITEMS);
      drain();
    end

    // Let the block sit idle a little so that any stray result would still be caught.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
